### rtl/weighted_priority_queue_scheduler_macros.svh
// Assertion macros shared by the scheduler's checking code.
`ifndef WEIGHTED_PRIORITY_QUEUE_SCHEDULER_MACROS_SVH
`define WEIGHTED_PRIORITY_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define WPRQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WPRQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wprq_pkg.sv
// Shared types, codes and defaults of the weighted priority queue scheduler.
package wprq_pkg;

    localparam int LEVELS_DEF       = 256;
    localparam int POOL_DEPTH_DEF   = 1024;
    localparam int DATA_BITS_DEF    = 32;
    localparam int TRAFFIC_BITS_DEF = 16;
    localparam int TRAFFIC_RESET    = 16;
    localparam int GROUP            = 16;
    localparam int COUNT_BITS       = 11;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic REG_TRAFFIC  = 1'b0;
    localparam logic REG_MIN_PRIO = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_ALLOC,
        S_ENQ_COMMIT,
        S_PICK_GRP,
        S_PICK_LVL,
        S_DEQ_READ,
        S_DEQ_FETCH,
        S_DEQ_COMMIT,
        S_RND_CLEAR,
        S_RND_SUM,
        S_RND_DINIT,
        S_RND_DSEL,
        S_RND_DWAIT,
        S_RND_LINIT,
        S_RND_LSEL,
        S_RND_LWR
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic enq_alloc;
        logic enq_commit;
        logic pick_grp;
        logic pick_lvl;
        logic deq_read;
        logic deq_fetch;
        logic deq_commit;
        logic res_empty;
        logic rnd_clear;
        logic rnd_sum;
        logic div_init;
        logic div_start;
        logic div_store;
        logic left_init;
        logic left_read;
        logic left_write;
        logic idx_inc;
        logic idx_dec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic found;
        logic retried;
        logic round_skip;
        logic active_any;
        logic idx_last;
        logic idx_at_min;
        logic idx_nonempty;
        logic sum_zero;
        logic div_done;
        logic rem_zero;
    } dp_stat_t;

endpackage

### rtl/wprq_div.sv
// Restoring divider, one quotient bit per cycle.
module wprq_div #(
    parameter int PW   = 24,
    parameter int SUMW = 15
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [PW-1:0]   dividend,
    input  logic [SUMW-1:0] divisor,
    output logic            done,
    output logic [PW-1:0]   quotient
);

    localparam int CW = $clog2(PW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [SUMW-1:0] rem_reg;
    logic [PW-1:0]   quo_reg;
    logic [SUMW-1:0] dvs_reg;
    logic [SUMW:0]   trial;
    logic            fits;

    assign trial = {rem_reg, quo_reg[PW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(PW);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (fits)
                    rem_reg <= SUMW'(trial - {1'b0, dvs_reg});
                else
                    rem_reg <= trial[SUMW-1:0];
                quo_reg <= {quo_reg[PW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/wprq_ctrl.sv
// Sequencer for enqueue, dequeue and round set-up.
module wprq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cmd,
    input  wprq_pkg::dp_stat_t   stat,
    output wprq_pkg::ctrl_cmd_t  ctl,
    output logic                 busy
);

    wprq_pkg::state_t state_reg;
    wprq_pkg::state_t state_next;
    logic             do_div;

    assign do_div = stat.idx_nonempty && !stat.sum_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wprq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wprq_pkg::S_IDLE:
                if (start)
                    state_next = (cmd == wprq_pkg::CMD_DEQ) ? wprq_pkg::S_PICK_GRP
                                                            : wprq_pkg::S_ENQ_ALLOC;
            wprq_pkg::S_ENQ_ALLOC:  state_next = wprq_pkg::S_ENQ_COMMIT;
            wprq_pkg::S_ENQ_COMMIT: state_next = wprq_pkg::S_IDLE;
            wprq_pkg::S_PICK_GRP:   state_next = wprq_pkg::S_PICK_LVL;
            wprq_pkg::S_PICK_LVL:   state_next = wprq_pkg::S_DEQ_READ;
            wprq_pkg::S_DEQ_READ:
                if (stat.found)
                    state_next = wprq_pkg::S_DEQ_FETCH;
                else if (stat.retried)
                    state_next = wprq_pkg::S_IDLE;
                else
                    state_next = wprq_pkg::S_RND_CLEAR;
            wprq_pkg::S_DEQ_FETCH:  state_next = wprq_pkg::S_DEQ_COMMIT;
            wprq_pkg::S_DEQ_COMMIT: state_next = wprq_pkg::S_IDLE;
            wprq_pkg::S_RND_CLEAR:
                state_next = stat.round_skip ? wprq_pkg::S_PICK_GRP : wprq_pkg::S_RND_SUM;
            wprq_pkg::S_RND_SUM:
                if (stat.idx_last)
                    state_next = wprq_pkg::S_RND_DINIT;
            wprq_pkg::S_RND_DINIT:
                state_next = stat.active_any ? wprq_pkg::S_RND_DSEL : wprq_pkg::S_PICK_GRP;
            wprq_pkg::S_RND_DSEL:
                if (do_div)
                    state_next = wprq_pkg::S_RND_DWAIT;
                else if (stat.idx_last)
                    state_next = wprq_pkg::S_RND_LINIT;
            wprq_pkg::S_RND_DWAIT:
                if (stat.div_done)
                    state_next = stat.idx_last ? wprq_pkg::S_RND_LINIT : wprq_pkg::S_RND_DSEL;
            wprq_pkg::S_RND_LINIT:  state_next = wprq_pkg::S_RND_LSEL;
            wprq_pkg::S_RND_LSEL:
                if (stat.rem_zero)
                    state_next = wprq_pkg::S_PICK_GRP;
                else if (stat.idx_nonempty)
                    state_next = wprq_pkg::S_RND_LWR;
                else if (stat.idx_at_min)
                    state_next = wprq_pkg::S_PICK_GRP;
            wprq_pkg::S_RND_LWR:
                state_next = stat.idx_at_min ? wprq_pkg::S_PICK_GRP : wprq_pkg::S_RND_LSEL;
            default: state_next = wprq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = (state_reg != wprq_pkg::S_IDLE);
        unique case (state_reg)
            wprq_pkg::S_IDLE:       ctl.latch_in   = start;
            wprq_pkg::S_ENQ_ALLOC:  ctl.enq_alloc  = 1'b1;
            wprq_pkg::S_ENQ_COMMIT: ctl.enq_commit = 1'b1;
            wprq_pkg::S_PICK_GRP:   ctl.pick_grp   = 1'b1;
            wprq_pkg::S_PICK_LVL:   ctl.pick_lvl   = 1'b1;
            wprq_pkg::S_DEQ_READ:
            begin
                ctl.deq_read  = stat.found;
                ctl.res_empty = !stat.found && stat.retried;
            end
            wprq_pkg::S_DEQ_FETCH:  ctl.deq_fetch  = 1'b1;
            wprq_pkg::S_DEQ_COMMIT: ctl.deq_commit = 1'b1;
            wprq_pkg::S_RND_CLEAR:  ctl.rnd_clear  = 1'b1;
            wprq_pkg::S_RND_SUM:
            begin
                ctl.rnd_sum = 1'b1;
                ctl.idx_inc = !stat.idx_last;
            end
            wprq_pkg::S_RND_DINIT:  ctl.div_init   = 1'b1;
            wprq_pkg::S_RND_DSEL:
            begin
                ctl.div_start = do_div;
                ctl.idx_inc   = !do_div && !stat.idx_last;
            end
            wprq_pkg::S_RND_DWAIT:
            begin
                ctl.div_store = stat.div_done;
                ctl.idx_inc   = stat.div_done && !stat.idx_last;
            end
            wprq_pkg::S_RND_LINIT:  ctl.left_init  = 1'b1;
            wprq_pkg::S_RND_LSEL:
            begin
                ctl.left_read = !stat.rem_zero && stat.idx_nonempty;
                ctl.idx_dec   = !stat.rem_zero && !stat.idx_nonempty && !stat.idx_at_min;
            end
            wprq_pkg::S_RND_LWR:
            begin
                ctl.left_write = 1'b1;
                ctl.idx_dec    = !stat.idx_at_min;
            end
            default: ctl = '0;
        endcase
    end

endmodule

### rtl/wprq_dp.sv
// Datapath: level lists, packet pool, quota store, level picker and round arithmetic.
module wprq_dp #(
    parameter int LEVELS       = wprq_pkg::LEVELS_DEF,
    parameter int POOL_DEPTH   = wprq_pkg::POOL_DEPTH_DEF,
    parameter int DATA_BITS    = wprq_pkg::DATA_BITS_DEF,
    parameter int TRAFFIC_BITS = wprq_pkg::TRAFFIC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wprq_pkg::ctrl_cmd_t                 ctl,
    output wprq_pkg::dp_stat_t                  stat,
    input  logic [7:0]                          priority_req,
    input  logic [DATA_BITS-1:0]                data_in,
    input  logic [TRAFFIC_BITS-1:0]             traffic,
    input  logic [7:0]                          min_prio,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [DATA_BITS-1:0]                data_out,
    output logic [7:0]                          priority_out,
    output logic [wprq_pkg::COUNT_BITS-1:0]     stored_count
);

    localparam int LW   = $clog2(LEVELS);
    localparam int PTRW = $clog2(POOL_DEPTH);
    localparam int CNTW = PTRW + 1;
    localparam int HW   = (CNTW > wprq_pkg::COUNT_BITS) ? CNTW : wprq_pkg::COUNT_BITS;
    localparam int SUMW = $clog2(LEVELS * (LEVELS - 1) / 2 + 1);
    localparam int PW   = LW + TRAFFIC_BITS;
    localparam int NG   = (LEVELS + wprq_pkg::GROUP - 1) / wprq_pkg::GROUP;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int GIW  = $clog2(wprq_pkg::GROUP);

    // storage
    logic [PTRW-1:0]         head_mem  [LEVELS];
    logic [PTRW-1:0]         tail_mem  [LEVELS];
    logic [TRAFFIC_BITS-1:0] quota_mem [LEVELS];
    logic [PTRW-1:0]         link_mem  [POOL_DEPTH];
    logic [DATA_BITS-1:0]    pkt_mem   [POOL_DEPTH];

    logic [PTRW-1:0]         head_q;
    logic [PTRW-1:0]         tail_q;
    logic [TRAFFIC_BITS-1:0] quota_q;
    logic                    qv_q;
    logic [PTRW-1:0]         link_q;
    logic [DATA_BITS-1:0]    pkt_q;

    logic [LEVELS-1:0]       nonempty_reg;
    logic [LEVELS-1:0]       elig_reg;
    logic [LEVELS-1:0]       qvalid_reg;

    logic [CNTW-1:0]         fresh_reg;
    logic [CNTW-1:0]         held_reg;
    logic [PTRW-1:0]         rec_head_reg;
    logic                    rec_valid_reg;
    logic [LW-1:0]           lvl_reg;
    logic [DATA_BITS-1:0]    data_reg;
    logic [PTRW-1:0]         slot_reg;
    logic                    use_rec_reg;
    logic                    rec_multi_reg;
    logic                    full_reg;
    logic [GW-1:0]           grp_reg;
    logic                    grp_any_reg;
    logic                    found_reg;
    logic                    retried_reg;
    logic [LW-1:0]           idx_reg;
    logic [SUMW-1:0]         sum_reg;
    logic                    active_reg;
    logic [TRAFFIC_BITS-1:0] assigned_reg;
    logic [TRAFFIC_BITS-1:0] rem_reg;

    logic                    done_reg;
    logic [1:0]              status_reg;
    logic [DATA_BITS-1:0]    data_out_reg;
    logic [7:0]              prio_out_reg;
    logic [wprq_pkg::COUNT_BITS-1:0] count_reg;

    // combinational
    logic [CNTW-1:0]         pool_len;
    logic                    enq_ok;
    logic                    deq_last;
    logic [TRAFFIC_BITS-1:0] qval;
    logic [TRAFFIC_BITS-1:0] qdec;
    logic [TRAFFIC_BITS-1:0] qinc;
    logic                    quota_we;
    logic [LW-1:0]           quota_waddr;
    logic [TRAFFIC_BITS-1:0] quota_wdata;
    logic                    quota_re;
    logic [LW-1:0]           quota_raddr;
    logic                    link_we;
    logic [PTRW-1:0]         link_waddr;
    logic [PTRW-1:0]         link_wdata;
    logic                    link_re;
    logic [PTRW-1:0]         link_raddr;
    logic                    head_we;
    logic [PTRW-1:0]         head_wdata;
    logic [NG*wprq_pkg::GROUP-1:0] elig_pad;
    logic [NG-1:0]           grp_any;
    logic [GW-1:0]           top_grp;
    logic [wprq_pkg::GROUP-1:0] sub_vec;
    logic [GIW-1:0]          top_bit;
    logic [LW-1:0]           lvl_sat;
    logic [PW-1:0]           product;
    logic                    div_done;
    logic [PW-1:0]           div_quo;
    logic [CNTW-1:0]         cnt_sel;
    logic [HW-1:0]           cnt_wide;

    assign pool_len = fresh_reg - held_reg;
    assign enq_ok   = ctl.enq_commit && !full_reg;
    assign deq_last = (slot_reg == tail_q);
    assign qval     = qv_q ? quota_q : '0;
    assign qdec     = qval - 1'b1;
    assign qinc     = qval + 1'b1;
    assign lvl_sat  = (32'(priority_req) >= LEVELS) ? LW'(LEVELS - 1) : LW'(priority_req);
    assign product  = PW'(idx_reg) * PW'(traffic);

    // quota store port selection
    always_comb
    begin
        quota_we    = ctl.deq_commit || ctl.div_store || ctl.left_write;
        quota_waddr = ctl.deq_commit ? lvl_reg : idx_reg;
        if (ctl.deq_commit)
            quota_wdata = deq_last ? '0 : qdec;
        else if (ctl.div_store)
            quota_wdata = div_quo[TRAFFIC_BITS-1:0];
        else
            quota_wdata = qinc;
        quota_re    = ctl.deq_read || ctl.left_read;
        quota_raddr = ctl.left_read ? idx_reg : lvl_reg;
    end

    // link and head port selection
    always_comb
    begin
        link_we    = ctl.deq_commit || (enq_ok && nonempty_reg[lvl_reg]);
        link_waddr = ctl.deq_commit ? slot_reg : tail_q;
        if (ctl.deq_commit)
            link_wdata = rec_valid_reg ? rec_head_reg : '0;
        else
            link_wdata = slot_reg;
        link_re    = ctl.enq_alloc || ctl.deq_fetch;
        link_raddr = ctl.enq_alloc ? rec_head_reg : head_q;
        head_we    = (ctl.deq_commit && !deq_last) || (enq_ok && !nonempty_reg[lvl_reg]);
        head_wdata = ctl.deq_commit ? link_q : slot_reg;
    end

    // two-level highest-bit search over the eligible vector
    assign elig_pad = (NG * wprq_pkg::GROUP)'(elig_reg);

    always_comb
    begin
        top_grp = '0;
        for (int g = 0; g < NG; g++)
        begin
            grp_any[g] = |elig_pad[g*wprq_pkg::GROUP +: wprq_pkg::GROUP];
            if (grp_any[g])
                top_grp = GW'(g);
        end
    end

    assign sub_vec = elig_pad[grp_reg*wprq_pkg::GROUP +: wprq_pkg::GROUP];

    always_comb
    begin
        top_bit = '0;
        for (int b = 0; b < wprq_pkg::GROUP; b++)
            if (sub_vec[b])
                top_bit = GIW'(b);
    end

    // result count
    always_comb
    begin
        if (ctl.enq_commit)
            cnt_sel = full_reg ? held_reg : held_reg + 1'b1;
        else if (ctl.deq_commit)
            cnt_sel = held_reg - 1'b1;
        else
            cnt_sel = held_reg;
        cnt_wide = HW'(cnt_sel);
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[lvl_reg] <= head_wdata;
        if (ctl.deq_read)
            head_q <= head_mem[lvl_reg];
    end

    always_ff @(posedge clk)
    begin
        if (enq_ok)
            tail_mem[lvl_reg] <= slot_reg;
        if (ctl.enq_alloc || ctl.deq_read)
            tail_q <= tail_mem[lvl_reg];
    end

    always_ff @(posedge clk)
    begin
        if (quota_we)
            quota_mem[quota_waddr] <= quota_wdata;
        if (quota_re)
        begin
            quota_q <= quota_mem[quota_raddr];
            qv_q    <= qvalid_reg[quota_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        if (link_re)
            link_q <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (enq_ok)
            pkt_mem[slot_reg] <= data_reg;
        if (ctl.deq_fetch)
            pkt_q <= pkt_mem[head_q];
    end

    wprq_div #(
        .PW   (PW),
        .SUMW (SUMW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (product),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg  <= '0;
            elig_reg      <= '0;
            qvalid_reg    <= '0;
            fresh_reg     <= '0;
            held_reg      <= '0;
            rec_head_reg  <= '0;
            rec_valid_reg <= 1'b0;
            lvl_reg       <= '0;
            data_reg      <= '0;
            slot_reg      <= '0;
            use_rec_reg   <= 1'b0;
            rec_multi_reg <= 1'b0;
            full_reg      <= 1'b0;
            grp_reg       <= '0;
            grp_any_reg   <= 1'b0;
            found_reg     <= 1'b0;
            retried_reg   <= 1'b0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            active_reg    <= 1'b0;
            assigned_reg  <= '0;
            rem_reg       <= '0;
            done_reg      <= 1'b0;
            status_reg    <= wprq_pkg::ST_OK;
            data_out_reg  <= '0;
            prio_out_reg  <= '0;
            count_reg     <= '0;
        end
        else
        begin
            done_reg <= ctl.enq_commit || ctl.deq_commit || ctl.res_empty;

            if (ctl.latch_in)
            begin
                lvl_reg     <= lvl_sat;
                data_reg    <= data_in;
                retried_reg <= 1'b0;
            end

            // slot allocation: recycled list first, then fresh slots
            if (ctl.enq_alloc)
            begin
                full_reg      <= 1'b0;
                use_rec_reg   <= 1'b0;
                rec_multi_reg <= pool_len > CNTW'(1);
                if (rec_valid_reg)
                begin
                    slot_reg    <= rec_head_reg;
                    use_rec_reg <= 1'b1;
                end
                else if (fresh_reg < CNTW'(POOL_DEPTH))
                begin
                    slot_reg  <= fresh_reg[PTRW-1:0];
                    fresh_reg <= fresh_reg + 1'b1;
                end
                else
                    full_reg <= 1'b1;
            end

            if (ctl.enq_commit)
            begin
                status_reg   <= full_reg ? wprq_pkg::ST_FULL : wprq_pkg::ST_OK;
                data_out_reg <= '0;
                prio_out_reg <= '0;
                count_reg    <= cnt_wide[wprq_pkg::COUNT_BITS-1:0];
            end

            if (enq_ok)
            begin
                if (use_rec_reg)
                begin
                    if (rec_multi_reg)
                        rec_head_reg <= link_q;
                    else
                        rec_valid_reg <= 1'b0;
                end
                nonempty_reg[lvl_reg] <= 1'b1;
                held_reg <= held_reg + 1'b1;
            end

            if (ctl.pick_grp)
            begin
                grp_reg     <= top_grp;
                grp_any_reg <= |grp_any;
            end

            if (ctl.pick_lvl)
            begin
                lvl_reg   <= LW'({grp_reg, top_bit});
                found_reg <= grp_any_reg;
            end

            if (ctl.deq_fetch)
                slot_reg <= head_q;

            if (ctl.deq_commit)
            begin
                status_reg    <= wprq_pkg::ST_OK;
                data_out_reg  <= pkt_q;
                prio_out_reg  <= 8'(lvl_reg);
                count_reg     <= cnt_wide[wprq_pkg::COUNT_BITS-1:0];
                held_reg      <= held_reg - 1'b1;
                rec_head_reg  <= slot_reg;
                rec_valid_reg <= 1'b1;
                if (deq_last)
                    nonempty_reg[lvl_reg] <= 1'b0;
            end

            if (ctl.res_empty)
            begin
                status_reg   <= wprq_pkg::ST_EMPTY;
                data_out_reg <= '0;
                prio_out_reg <= '0;
                count_reg    <= cnt_wide[wprq_pkg::COUNT_BITS-1:0];
            end

            // round set-up
            if (ctl.rnd_clear)
            begin
                elig_reg    <= '0;
                qvalid_reg  <= '0;
                sum_reg     <= '0;
                active_reg  <= 1'b0;
                idx_reg     <= LW'(min_prio);
                retried_reg <= 1'b1;
            end

            if (ctl.rnd_sum && nonempty_reg[idx_reg])
            begin
                sum_reg    <= sum_reg + SUMW'(idx_reg);
                active_reg <= 1'b1;
            end

            if (ctl.div_init)
            begin
                idx_reg      <= LW'(min_prio);
                assigned_reg <= '0;
            end

            if (ctl.div_store)
                assigned_reg <= assigned_reg + div_quo[TRAFFIC_BITS-1:0];

            if (ctl.left_init)
            begin
                rem_reg <= traffic - assigned_reg;
                idx_reg <= LW'(LEVELS - 1);
            end

            if (ctl.left_write)
                rem_reg <= rem_reg - 1'b1;

            if (ctl.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            else if (ctl.idx_dec)
                idx_reg <= idx_reg - 1'b1;

            if (quota_we)
            begin
                qvalid_reg[quota_waddr] <= 1'b1;
                elig_reg[quota_waddr]   <= (quota_wdata != '0);
            end
        end
    end

    always_comb
    begin
        stat.found        = found_reg;
        stat.retried      = retried_reg;
        stat.round_skip   = (32'(min_prio) >= LEVELS) || (traffic == '0);
        stat.active_any   = active_reg;
        stat.idx_last     = (idx_reg == LW'(LEVELS - 1));
        stat.idx_at_min   = (32'(idx_reg) == 32'(min_prio));
        stat.idx_nonempty = nonempty_reg[idx_reg];
        stat.sum_zero     = (sum_reg == '0);
        stat.div_done     = div_done;
        stat.rem_zero     = (rem_reg == '0);
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign data_out     = data_out_reg;
    assign priority_out = prio_out_reg;
    assign stored_count = count_reg;

endmodule

### rtl/weighted_priority_queue_scheduler.sv
// Top level: weighted round-robin priority queue scheduler with APB register port.
// Enqueue: alloc and commit states, then done; a plain dequeue: group pick, level pick,
// read, fetch and commit, then done. The next transfer is taken at the edge ending the
// done cycle. A dequeue that opens a round adds a sum walk up from min_priority, a run
// of the shared bit-serial divider per level given a share, and the leftover walk.
// One transfer at a time; the receiver never stalls results.
module weighted_priority_queue_scheduler #(
    parameter int LEVELS       = wprq_pkg::LEVELS_DEF,
    parameter int POOL_DEPTH   = wprq_pkg::POOL_DEPTH_DEF,
    parameter int DATA_BITS    = wprq_pkg::DATA_BITS_DEF,
    parameter int TRAFFIC_BITS = wprq_pkg::TRAFFIC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic                             cmd,
    input  logic [7:0]                       priority_req,
    input  logic [DATA_BITS-1:0]             data_in,
    // result channel
    output logic                             done,
    output logic [1:0]                       status,
    output logic [DATA_BITS-1:0]             data_out,
    output logic [7:0]                       priority_out,
    output logic [wprq_pkg::COUNT_BITS-1:0]  stored_count,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    `include "weighted_priority_queue_scheduler_macros.svh"

    // rst_n is asynchronous: it empties all levels, quotas and the pool; no clearing pass.
    logic [TRAFFIC_BITS-1:0] traffic_reg;
    logic [7:0]              min_prio_reg;
    logic                    cfg_wr;

    wprq_pkg::ctrl_cmd_t     ctl;
    wprq_pkg::dp_stat_t      stat;

    // Zero-wait APB: a write transfer lands on the access phase edge.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            traffic_reg  <= TRAFFIC_BITS'(wprq_pkg::TRAFFIC_RESET);
            min_prio_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                wprq_pkg::REG_TRAFFIC:  traffic_reg  <= pwdata[TRAFFIC_BITS-1:0];
                wprq_pkg::REG_MIN_PRIO: min_prio_reg <= pwdata[7:0];
                default:                traffic_reg  <= traffic_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            wprq_pkg::REG_TRAFFIC:  prdata = 32'(traffic_reg);
            wprq_pkg::REG_MIN_PRIO: prdata = 32'(min_prio_reg);
            default:                prdata = '0;
        endcase
    end

    // Sequencer: one state per memory access step and per round walk step.
    wprq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Datapath: linked-list pool, quota store, level picker and divider.
    wprq_dp #(
        .LEVELS       (LEVELS),
        .POOL_DEPTH   (POOL_DEPTH),
        .DATA_BITS    (DATA_BITS),
        .TRAFFIC_BITS (TRAFFIC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .priority_req (priority_req),
        .data_in      (data_in),
        .traffic      (traffic_reg),
        .min_prio     (min_prio_reg),
        .done         (done),
        .status       (status),
        .data_out     (data_out),
        .priority_out (priority_out),
        .stored_count (stored_count)
    );

    // Checks on the sequencing and the result contents.
    `WPRQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
    `WPRQ_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while sequencer busy")
    `WPRQ_ASSERT_IMP(a_fail_zero, done && status != wprq_pkg::ST_OK, data_out == '0 && priority_out == '0, "failed transfer carries data")
    `WPRQ_ASSERT_IMP(a_count_range, done, 32'(stored_count) <= POOL_DEPTH, "stored count beyond pool depth")

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of the weighted priority queue scheduler.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLEV  = 256;
    localparam int NPOOL = 1024;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  prio;
        logic [31:0] data;
    } sched_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
        logic [7:0]  prio;
        logic [10:0] count;
    } sched_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = 1'b0;
    logic [7:0]  priority_req = '0;
    logic [31:0] data_in = '0;
    logic        done;
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [7:0]  priority_out;
    logic [10:0] stored_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    weighted_priority_queue_scheduler u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .priority_req(priority_req), .data_in(data_in), .done(done),
        .status(status), .data_out(data_out), .priority_out(priority_out),
        .stored_count(stored_count), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---- scheduler shadow: linked-list pool, per-level quotas ----
    logic [15:0] sh_traffic;
    logic [7:0]  sh_min_prio;
    logic [9:0]  sh_head  [NLEV];
    logic [9:0]  sh_tail  [NLEV];
    logic        sh_busy_lvl [NLEV];
    logic [15:0] sh_quota [NLEV];
    logic [9:0]  sh_link  [NPOOL];
    logic [31:0] sh_store [NPOOL];
    int unsigned sh_fresh;
    logic [9:0]  sh_free_head;
    logic        sh_free_valid;
    int unsigned sh_held;

    sched_req_t  pending_reqs[$];
    sched_resp_t awaited_resps[$];

    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned accepted = 0;
    int unsigned served = 0;
    int unsigned full_seen = 0;
    int unsigned empty_seen = 0;
    int unsigned rounds_cfg = 0;
    int          gap = 0;
    logic        busy_at_rise;

    function automatic int next_level();
        for (int l = NLEV - 1; l >= 0; l--)
            if (sh_busy_lvl[l] && sh_quota[l] != 0)
                return l;
        return -1;
    endfunction

    // new round: proportional share by level, then leftover one each from the top
    function automatic void share_round();
        int unsigned lsum;
        int unsigned nact;
        longint unsigned given;
        longint unsigned left;
        longint unsigned q;
        lsum = 0;
        nact = 0;
        given = 0;
        for (int l = 0; l < NLEV; l++)
            sh_quota[l] = '0;
        for (int l = sh_min_prio; l < NLEV; l++)
            if (sh_busy_lvl[l])
            begin
                lsum += l;
                nact++;
            end
        if (nact == 0 || sh_traffic == 0)
            return;
        for (int l = sh_min_prio; l < NLEV; l++)
            if (sh_busy_lvl[l])
            begin
                q = (lsum == 0) ? 0 : (longint'(l) * sh_traffic) / lsum;
                sh_quota[l] = q[15:0];
                given += q;
            end
        left = (given < sh_traffic) ? sh_traffic - given : 0;
        for (int k = NLEV - 1; k >= int'(sh_min_prio) && left > 0; k--)
            if (sh_busy_lvl[k])
            begin
                sh_quota[k] = sh_quota[k] + 16'd1;
                left--;
            end
    endfunction

    function automatic sched_resp_t schedule_step(sched_req_t r);
        sched_resp_t o;
        int unsigned lvl;
        int          l;
        logic [9:0]  n;
        logic        ok;
        o = '0;
        if (r.cmd == wprq_pkg::CMD_ENQ)
        begin
            lvl = r.prio;
            ok = 1'b1;
            if (sh_free_valid)
            begin
                n = sh_free_head;
                if (sh_fresh - sh_held > 1)
                    sh_free_head = sh_link[n];
                else
                    sh_free_valid = 1'b0;
            end
            else if (sh_fresh < NPOOL)
            begin
                n = sh_fresh[9:0];
                sh_fresh++;
            end
            else
            begin
                ok = 1'b0;
                n = '0;
            end
            if (!ok)
                o.status = wprq_pkg::ST_FULL;
            else
            begin
                sh_store[n] = r.data;
                if (sh_busy_lvl[lvl])
                    sh_link[sh_tail[lvl]] = n;
                else
                begin
                    sh_head[lvl] = n;
                    sh_busy_lvl[lvl] = 1'b1;
                end
                sh_tail[lvl] = n;
                sh_held++;
            end
        end
        else
        begin
            l = next_level();
            if (l < 0)
            begin
                share_round();
                l = next_level();
            end
            if (l < 0)
                o.status = wprq_pkg::ST_EMPTY;
            else
            begin
                n = sh_head[l];
                o.data = sh_store[n];
                o.prio = l[7:0];
                sh_quota[l] = sh_quota[l] - 16'd1;
                if (n == sh_tail[l])
                begin
                    sh_busy_lvl[l] = 1'b0;
                    sh_quota[l] = '0;
                end
                else
                    sh_head[l] = sh_link[n];
                sh_held--;
                sh_link[n] = sh_free_valid ? sh_free_head : '0;
                sh_free_head = n;
                sh_free_valid = 1'b1;
                served++;
            end
        end
        o.count = sh_held[10:0];
        return o;
    endfunction

    task automatic load_next();
        sched_req_t r;
        r = pending_reqs.pop_front();
        cmd          <= r.cmd;
        priority_req <= r.prio;
        data_in      <= r.data;
        start        <= 1'b1;
        gap           = $urandom_range(0, 7);
        awaited_resps.push_back(schedule_step(r));
        accepted++;
    endtask

    always @(posedge clk)
    begin
        busy_at_rise <= busy;
    end

    // ---- driver: one command per transfer, random hold-off before each ----
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy_at_rise)
            begin
                // previous transfer was taken at the last rising edge
                if (gap == 0 && pending_reqs.size() > 0)
                    load_next();
                else
                    start <= 1'b0;
            end
            else if (!start)
            begin
                if (gap > 0)
                    gap--;
                else if (pending_reqs.size() > 0)
                    load_next();
            end
        end
    end

    // ---- monitor: every done strobe is checked against the oldest prediction ----
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (awaited_resps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: st=%0d data=%h prio=%0d cnt=%0d",
                             status, data_out, priority_out, stored_count);
            end
            else
            begin
                sched_resp_t e;
                e = awaited_resps.pop_front();
                if (e.status == wprq_pkg::ST_FULL)
                    full_seen++;
                if (e.status == wprq_pkg::ST_EMPTY)
                    empty_seen++;
                if (status !== e.status || data_out !== e.data ||
                    priority_out !== e.prio || stored_count !== e.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%h/%0d/%0d, got %0d/%h/%0d/%0d",
                                 e.status, e.data, e.prio, e.count,
                                 status, data_out, priority_out, stored_count);
                end
            end
        end
    end

    // ---- watchdog ----
    always @(posedge clk)
    begin
        if (cycles > 20000000)
        begin
            $display("weighted_priority_queue_scheduler test failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || start || awaited_resps.size() > 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // register write: setup then access, driven on falling edges
    task automatic reg_write(input logic idx, input logic [31:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == wprq_pkg::REG_TRAFFIC)
            sh_traffic = v[15:0];
        else
            sh_min_prio = v[7:0];
        rounds_cfg++;
    endtask

    function automatic sched_req_t mk(logic c, logic [7:0] p, logic [31:0] d);
        sched_req_t r;
        r.cmd = c;
        r.prio = p;
        r.data = d;
        return r;
    endfunction

    // one phase of random traffic: enq_pct percent enqueues, the rest dequeues, mostly to a few levels unless wide
    task automatic random_phase(input int n, input int enq_pct, input logic wide);
        logic [7:0] p;
        for (int i = 0; i < n; i++)
        begin
            if (wide || $urandom_range(0, 3) == 0)
                p = 8'($urandom_range(0, 255));
            else
                p = 8'($urandom_range(0, 6) * 37);
            pending_reqs.push_back(mk(($urandom_range(0, 99) < enq_pct) ? wprq_pkg::CMD_ENQ
                                                                         : wprq_pkg::CMD_DEQ,
                                      p, $urandom()));
        end
        wait_idle();
    endtask

    initial
    begin
        sh_traffic = 16'd16;
        sh_min_prio = '0;
        for (int l = 0; l < NLEV; l++)
        begin
            sh_busy_lvl[l] = 1'b0;
            sh_quota[l] = '0;
        end
        sh_fresh = 0;
        sh_free_valid = 1'b0;
        sh_free_head = '0;
        sh_held = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty dequeue, extreme levels and handles, level 0 alone
        pending_reqs.push_back(mk(wprq_pkg::CMD_DEQ, 8'd0, 32'd0));
        pending_reqs.push_back(mk(wprq_pkg::CMD_ENQ, 8'd0, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk(wprq_pkg::CMD_DEQ, 8'd0, 32'd0));
        pending_reqs.push_back(mk(wprq_pkg::CMD_ENQ, 8'd255, 32'h0000_0000));
        pending_reqs.push_back(mk(wprq_pkg::CMD_ENQ, 8'd255, 32'hA5A5_5A5A));
        pending_reqs.push_back(mk(wprq_pkg::CMD_ENQ, 8'd1, 32'h5A5A_A5A5));
        pending_reqs.push_back(mk(wprq_pkg::CMD_ENQ, 8'd128, 32'h8000_0001));
        pending_reqs.push_back(mk(wprq_pkg::CMD_ENQ, 8'd0, 32'h7FFF_FFFE));
        for (int i = 0; i < 7; i++)
            pending_reqs.push_back(mk(wprq_pkg::CMD_DEQ, 8'hFF, 32'hFFFF_FFFF));
        wait_idle();

        // zero traffic: nothing served even with packets stored
        reg_write(wprq_pkg::REG_TRAFFIC, 32'd0);
        pending_reqs.push_back(mk(wprq_pkg::CMD_ENQ, 8'd10, 32'h1234_5678));
        pending_reqs.push_back(mk(wprq_pkg::CMD_DEQ, 8'd0, 32'd0));
        wait_idle();
        reg_write(wprq_pkg::REG_TRAFFIC, 32'hFFFF);
        pending_reqs.push_back(mk(wprq_pkg::CMD_DEQ, 8'd0, 32'd0));
        wait_idle();

        // minimum at the top: only level 255 eligible
        reg_write(wprq_pkg::REG_MIN_PRIO, 32'd255);
        pending_reqs.push_back(mk(wprq_pkg::CMD_ENQ, 8'd254, 32'hCAFE_0001));
        pending_reqs.push_back(mk(wprq_pkg::CMD_DEQ, 8'd0, 32'd0));
        pending_reqs.push_back(mk(wprq_pkg::CMD_ENQ, 8'd255, 32'hCAFE_0002));
        pending_reqs.push_back(mk(wprq_pkg::CMD_DEQ, 8'd0, 32'd0));
        wait_idle();

        // random phases across settings
        reg_write(wprq_pkg::REG_MIN_PRIO, 32'd0);
        reg_write(wprq_pkg::REG_TRAFFIC, 32'd5);
        random_phase(90, 60, 1'b0);
        reg_write(wprq_pkg::REG_TRAFFIC, 32'd1);
        random_phase(70, 50, 1'b0);
        reg_write(wprq_pkg::REG_MIN_PRIO, 32'd100);
        reg_write(wprq_pkg::REG_TRAFFIC, 32'd40);
        random_phase(70, 55, 1'b1);
        reg_write(wprq_pkg::REG_MIN_PRIO, 32'd0);
        reg_write(wprq_pkg::REG_TRAFFIC, 32'hFFFF);
        random_phase(80, 50, 1'b1);
        reg_write(wprq_pkg::REG_TRAFFIC, 32'd16);
        random_phase(90, 45, 1'b0);

        // drain: dequeues only, down to empty replies
        random_phase(30, 0, 1'b0);

        $display("%0d commands, %0d packets served, %0d full and %0d empty replies, %0d reg writes",
                 accepted, served, full_seen, empty_seen, rounds_cfg);
        if (mismatches == 0)
            $display("weighted_priority_queue_scheduler test passed");
        else
            $display("weighted_priority_queue_scheduler test failed");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/wprq_pkg.sv
rtl/wprq_div.sv
rtl/wprq_ctrl.sv
rtl/wprq_dp.sv
rtl/weighted_priority_queue_scheduler.sv
tb/sv/tb_top.sv
